// ----- rtl/assert_macros.svh -----
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, off while in reset
`define TLVD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tlvd assertion failed");

// consequent checked in the clock after the antecedent
`define TLVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlvd assertion failed");

`endif

// ----- rtl/tlvd_pkg.sv -----
package tlvd_pkg;

    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 16;

    typedef enum logic [2:0] {
        PH_CNT_HI,
        PH_CNT_LO,
        PH_ID_HI,
        PH_ID_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_EMPTY,
        KIND_STATUS
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_TRUNC,
        ST_TRAIL
    } t_status;

    typedef struct packed {
        t_kind                kind;
        logic [FIELD_W-1:0]   field_id;
        logic [FIELD_W-1:0]   field_length;
        logic [BYTE_W-1:0]    data_value;
        logic [FIELD_W-1:0]   byte_offset;
        logic                 field_end;
        logic                 message_end;
        t_status              status;
    } t_result;

endpackage

// ----- rtl/tlvd_stream_if.sv -----
interface tlvd_in_if;
    import tlvd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source(output valid, data_byte, last_byte, input ready);
    modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface tlvd_out_if;
    import tlvd_pkg::*;

    logic               valid;
    logic               ready;
    t_kind              kind;
    logic [FIELD_W-1:0] field_id;
    logic [FIELD_W-1:0] field_length;
    logic [BYTE_W-1:0]  data_value;
    logic [FIELD_W-1:0] byte_offset;
    logic               field_end;
    logic               message_end;
    t_status            status;

    modport source(
        output valid, kind, field_id, field_length, data_value, byte_offset,
               field_end, message_end, status,
        input  ready
    );
    modport sink(
        input  valid, kind, field_id, field_length, data_value, byte_offset,
               field_end, message_end, status,
        output ready
    );
endinterface

// ----- rtl/tlv_field_list_decoder_unit.sv -----
// Streaming decoder for field-list messages: a big-endian 16-bit field count, then per field a
// 16-bit id, a 16-bit length and that many data bytes. One input beat is one message byte, with
// last_byte marking the final byte. Each data byte comes out tagged with id, length and offset;
// a zero-length field gives one empty-field beat; the last byte's beat carries message_end and
// the status (ok, truncated, trailing bytes). Other bytes give no output beat. The block takes
// one byte every clock unless a stalled output holds it back: the parser state sits between
// an input register and an output register, and a stalled output holds back the input only
// when the waiting byte gives a beat.
module tlv_field_list_decoder_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    tlvd_in_if.sink    i_in,
    tlvd_out_if.source o_out
);
    import tlvd_pkg::*;

    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_data;
    logic              r_s1_last;
    logic              r_out_valid;
    t_result           r_out;

    logic    core_emit;
    t_result core_result;
    logic    out_free;
    logic    s1_move;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_move    = r_s1_valid && (!core_emit || out_free);
    assign i_in.ready = !r_s1_valid || s1_move;

    tlvd_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_move),
        .i_data_byte (r_s1_data),
        .i_last_byte (r_s1_last),
        .o_emit      (core_emit),
        .o_result    (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_data <= i_in.data_byte;
            r_s1_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && core_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && core_emit) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.field_id     = r_out.field_id;
    assign o_out.field_length = r_out.field_length;
    assign o_out.data_value   = r_out.data_value;
    assign o_out.byte_offset  = r_out.byte_offset;
    assign o_out.field_end    = r_out.field_end;
    assign o_out.message_end  = r_out.message_end;
    assign o_out.status       = r_out.status;

endmodule

// ----- rtl/tlvd_parse_core.sv -----
`include "assert_macros.svh"

module tlvd_parse_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic [tlvd_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                       i_last_byte,
    output logic                       o_emit,
    output tlvd_pkg::t_result          o_result
);
    import tlvd_pkg::*;

    t_phase             r_phase, n_phase;
    logic [FIELD_W-1:0] r_fields_left, n_fields_left;
    logic [FIELD_W-1:0] r_current_id, n_current_id;
    logic [FIELD_W-1:0] r_current_length, n_current_length;
    logic [FIELD_W-1:0] r_bytes_done, n_bytes_done;
    logic [BYTE_W-1:0]  r_high_byte_hold, n_high_byte_hold;
    logic               r_overrun, n_overrun;

    always_comb begin
        n_phase          = r_phase;
        n_fields_left    = r_fields_left;
        n_current_id     = r_current_id;
        n_current_length = r_current_length;
        n_bytes_done     = r_bytes_done;
        n_high_byte_hold = r_high_byte_hold;
        n_overrun        = r_overrun;
        o_emit           = 1'b0;
        o_result         = '0;
        o_result.kind    = KIND_STATUS;
        o_result.status  = ST_OK;

        case (r_phase)
            PH_CNT_HI, PH_ID_HI, PH_LEN_HI: begin
                n_high_byte_hold = i_data_byte;
                n_phase          = t_phase'(r_phase + 3'd1);
            end
            PH_CNT_LO: begin
                n_fields_left = {r_high_byte_hold, i_data_byte};
                n_phase       = (n_fields_left != '0) ? PH_ID_HI : PH_DONE;
            end
            PH_ID_LO: begin
                n_current_id = {r_high_byte_hold, i_data_byte};
                n_phase      = PH_LEN_HI;
            end
            PH_LEN_LO: begin
                n_current_length = {r_high_byte_hold, i_data_byte};
                n_bytes_done     = '0;
                if (n_current_length == '0) begin
                    o_emit             = 1'b1;
                    o_result.kind      = KIND_EMPTY;
                    o_result.field_id  = r_current_id;
                    o_result.field_end = 1'b1;
                    n_fields_left      = r_fields_left - FIELD_W'(1);
                    n_phase            = (n_fields_left != '0) ? PH_ID_HI : PH_DONE;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                o_emit                = 1'b1;
                o_result.kind         = KIND_DATA;
                o_result.field_id     = r_current_id;
                o_result.field_length = r_current_length;
                o_result.data_value   = i_data_byte;
                o_result.byte_offset  = r_bytes_done;
                n_bytes_done          = r_bytes_done + FIELD_W'(1);
                if (n_bytes_done == r_current_length) begin
                    o_result.field_end = 1'b1;
                    n_fields_left      = r_fields_left - FIELD_W'(1);
                    n_phase            = (n_fields_left != '0) ? PH_ID_HI : PH_DONE;
                end
            end
            default: begin
                n_overrun = 1'b1;
            end
        endcase

        if (i_last_byte) begin
            o_emit               = 1'b1;
            o_result.message_end = 1'b1;
            if (n_overrun) begin
                o_result.status = ST_TRAIL;
            end else if (n_phase == PH_DONE) begin
                o_result.status = ST_OK;
            end else begin
                o_result.status = ST_TRUNC;
            end
            n_phase          = PH_CNT_HI;
            n_fields_left    = '0;
            n_current_id     = '0;
            n_current_length = '0;
            n_bytes_done     = '0;
            n_high_byte_hold = '0;
            n_overrun        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_CNT_HI;
            r_fields_left    <= '0;
            r_current_id     <= '0;
            r_current_length <= '0;
            r_bytes_done     <= '0;
            r_high_byte_hold <= '0;
            r_overrun        <= 1'b0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_fields_left    <= n_fields_left;
            r_current_id     <= n_current_id;
            r_current_length <= n_current_length;
            r_bytes_done     <= n_bytes_done;
            r_high_byte_hold <= n_high_byte_hold;
            r_overrun        <= n_overrun;
        end
    end

    // data phase only with a nonzero length and offset still inside the field
    `TLVD_ASSERT(a_data_in_range, i_clk, i_rst_n,
        r_phase != PH_DATA || r_bytes_done < r_current_length)
    // overrun only once all fields are done
    `TLVD_ASSERT(a_overrun_done, i_clk, i_rst_n, !r_overrun || r_phase == PH_DONE)
    // last beat returns the parser to its start state
    `TLVD_ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, i_step && i_last_byte,
        r_phase == PH_CNT_HI && !r_overrun && r_fields_left == '0)

endmodule
